// File: hw/rtl/ptt_pkg.sv
// Shared types, codes and sizes of the periodic timer table.
package ptt_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

    localparam int HANDLER_W  = 8;
    localparam int CTX_W      = 16;
    localparam int PERIOD_W   = 32;
    localparam int TIME_W     = 48;

    typedef enum logic [1:0] {
        KIND_SET    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_NONE   = 2'd3
    } ptt_kind_t;

    typedef enum logic [2:0] {
        STAT_ADDED    = 3'd0,
        STAT_UPDATED  = 3'd1,
        STAT_REMOVED  = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_FULL     = 3'd4,
        STAT_EXPIRED  = 3'd5,
        STAT_IDLE     = 3'd6
    } ptt_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIND,
        ST_TICK,
        ST_SHIFT
    } ptt_state_t;

    typedef struct packed {
        logic [TIME_W-1:0]    due;
        logic [PERIOD_W-1:0]  interval;
        logic [CTX_W-1:0]     ctx;
        logic [HANDLER_W-1:0] handler;
    } ptt_entry_t;

endpackage

// File: hw/rtl/ptt_alu.sv
// Shared saturating 48-bit time adder and due-time compare.
module ptt_alu
    import ptt_pkg::*;
(
    input  logic [TIME_W-1:0]   base,
    input  logic [PERIOD_W-1:0] step,
    input  logic [TIME_W-1:0]   now,
    output logic [TIME_W-1:0]   sum_sat,
    output logic                reached
);

    logic [TIME_W:0] sum;

    assign sum     = {1'b0, base} + {{(TIME_W + 1 - PERIOD_W){1'b0}}, step};
    assign sum_sat = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    // base doubles as the due time on a tick
    assign reached = (now >= base);

endmodule

// File: hw/rtl/periodic_timer_table.sv
// Top level of the periodic timer table: sequencer, entry memory, result register.
//
// Usage:
//   s_* channel takes one request: tuser = kind (set, remove, tick, or an
//   unused code that is taken and dropped), tdata = key, period, time.
//   m_* channel returns results: tuser = status, tdata = key of the entry
//   concerned, tlast = last result of that request.
//   Set and remove give one result, a tick one per expired entry in table
//   order, or a single "none expired" result.
// Timing:
//   The table sits in a memory with one write and one read port, read one
//   entry per cycle unless a stalled output holds the scan. A set that
//   hits an entry stops the scan there; a remove that hits moves the later
//   entries down, one per cycle. Each request ends back in idle, and
//   s_tready is high only between requests.
//   A set or remove result is loaded into the output register once the scan
//   finds it and the register is free. A tick expiry is held until the next
//   one or the end of the scan, so the last tick result goes out as the scan
//   ends. The scan holds in place while the output register is full and
//   m_tready low, so a stalled receiver stalls the sequencer and nothing is
//   dropped.
// Reset:
//   aresetn (synchronous, active low) empties the table by clearing the
//   entry count; the memory itself needs no clearing pass.
module periodic_timer_table
    import ptt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [7:0] handler_id, [23:8] context_id, [55:24] period, [103:56] now_time
    input  logic [103:0] s_tdata,
    // [1:0] kind
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] timer_handler, [23:8] timer_context
    output logic [23:0]  m_tdata,
    // [2:0] status
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    ptt_state_t state_reg, state_next;

    // latched request
    ptt_kind_t            kind_reg;
    logic [HANDLER_W-1:0] hid_reg;
    logic [CTX_W-1:0]     cid_reg;
    logic [PERIOD_W-1:0]  per_reg;
    logic [TIME_W-1:0]    now_reg;

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // held expiry, sent once the next one (or the end of scan) is known
    logic                 pend_valid_reg, pend_valid_next;
    logic [HANDLER_W-1:0] pend_hid_reg, pend_hid_next;
    logic [CTX_W-1:0]     pend_cid_reg, pend_cid_next;

    // output register
    logic                 m_tvalid_reg;
    ptt_status_t          m_status_reg;
    logic [HANDLER_W-1:0] m_hid_reg;
    logic [CTX_W-1:0]     m_cid_reg;
    logic                 m_last_reg;

    logic                 out_load;
    ptt_status_t          out_status;
    logic [HANDLER_W-1:0] out_hid;
    logic [CTX_W-1:0]     out_cid;
    logic                 out_last;
    logic                 slot_free;

    // entry memory
    ptt_entry_t mem [NUM_TIMERS];
    ptt_entry_t rd_data_reg;
    logic       mem_we;
    logic [IDX_W-1:0] mem_waddr;
    ptt_entry_t mem_wdata;

    logic              s_accept;
    logic [TIME_W-1:0] alu_base;
    logic [PERIOD_W-1:0] alu_step;
    logic [TIME_W-1:0] alu_sum;
    logic              alu_reached;
    logic              in_range;
    logic              key_hit;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign in_range  = (idx_reg < cnt_reg);
    assign key_hit   = (rd_data_reg.handler == hid_reg) && (rd_data_reg.ctx == cid_reg);

    // one adder: now + period on set, due + interval on tick
    assign alu_base = (kind_reg == KIND_TICK) ? rd_data_reg.due : now_reg;
    assign alu_step = (kind_reg == KIND_TICK) ? rd_data_reg.interval : per_reg;

    ptt_alu u_alu (
        .base    (alu_base),
        .step    (alu_step),
        .now     (now_reg),
        .sum_sat (alu_sum),
        .reached (alu_reached)
    );

    // read address is the next index, so rd_data_reg tracks idx_reg
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[idx_next[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            kind_reg <= ptt_kind_t'(s_tuser);
            hid_reg  <= s_tdata[7:0];
            cid_reg  <= s_tdata[23:8];
            per_reg  <= s_tdata[55:24];
            now_reg  <= s_tdata[103:56];
        end
        pend_hid_reg <= pend_hid_next;
        pend_cid_reg <= pend_cid_next;
        if (out_load) begin
            m_status_reg <= out_status;
            m_hid_reg    <= out_hid;
            m_cid_reg    <= out_cid;
            m_last_reg   <= out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_hid_next   = pend_hid_reg;
        pend_cid_next   = pend_cid_reg;
        out_load        = 1'b0;
        out_status      = STAT_ADDED;
        out_hid         = hid_reg;
        out_cid         = cid_reg;
        out_last        = 1'b1;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg[IDX_W-1:0];
        mem_wdata       = '{due: alu_sum, interval: per_reg, ctx: cid_reg, handler: hid_reg};

        case (state_reg)
            ST_IDLE: begin
                idx_next = '0;
                if (s_accept) begin
                    case (ptt_kind_t'(s_tuser))
                        KIND_SET, KIND_REMOVE: state_next = ST_FIND;
                        KIND_TICK:             state_next = ST_TICK;
                        default:               state_next = ST_IDLE;
                    endcase
                end
            end

            ST_FIND: begin
                if (in_range && !key_hit) begin
                    idx_next = idx_reg + 1'b1;
                end else if (slot_free) begin
                    out_load = 1'b1;
                    if (in_range && kind_reg == KIND_SET) begin
                        out_status = STAT_UPDATED;
                        mem_we     = 1'b1;
                        state_next = ST_IDLE;
                    end else if (in_range) begin
                        // removed: close the gap from the next entry on
                        out_status = STAT_REMOVED;
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SHIFT;
                    end else if (kind_reg == KIND_SET) begin
                        state_next = ST_IDLE;
                        if (cnt_reg < CNT_W'(NUM_TIMERS)) begin
                            out_status = STAT_ADDED;
                            mem_we     = 1'b1;
                            mem_waddr  = cnt_reg[IDX_W-1:0];
                            cnt_next   = cnt_reg + 1'b1;
                        end else begin
                            out_status = STAT_FULL;
                        end
                    end else begin
                        out_status = STAT_NOTFOUND;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_SHIFT: begin
                if (in_range) begin
                    mem_we    = 1'b1;
                    mem_waddr = IDX_W'(idx_reg - 1'b1);
                    mem_wdata = rd_data_reg;
                    idx_next  = idx_reg + 1'b1;
                end else begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_TICK: begin
                if (in_range) begin
                    if (!alu_reached) begin
                        idx_next = idx_reg + 1'b1;
                    end else if (!pend_valid_reg || slot_free) begin
                        out_load        = pend_valid_reg;
                        out_status      = STAT_EXPIRED;
                        out_hid         = pend_hid_reg;
                        out_cid         = pend_cid_reg;
                        out_last        = 1'b0;
                        mem_we          = 1'b1;
                        mem_wdata       = rd_data_reg;
                        mem_wdata.due   = alu_sum;
                        pend_valid_next = 1'b1;
                        pend_hid_next   = rd_data_reg.handler;
                        pend_cid_next   = rd_data_reg.ctx;
                        idx_next        = idx_reg + 1'b1;
                    end
                end else if (slot_free) begin
                    out_load        = 1'b1;
                    out_status      = pend_valid_reg ? STAT_EXPIRED : STAT_IDLE;
                    out_hid         = pend_valid_reg ? pend_hid_reg : '0;
                    out_cid         = pend_valid_reg ? pend_cid_reg : '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_cid_reg, m_hid_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    // a new result never overwrites one the receiver has not taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(NUM_TIMERS))
        else $error("entry count above table size");

    a_pend_tick_only: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (state_reg == ST_TICK))
        else $error("held expiry outside a tick scan");

    a_shift_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT && !in_range) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("remove did not shrink the table");

endmodule

// File: verif/periodic_timer_table_test.sv
// Self-checking testbench of the periodic timer table: directed table, then random requests.
`timescale 1ns / 1ps

module periodic_timer_table_test
    import ptt_pkg::*;
();

    // Run length and receiver shaping in clock cycles, idle share in percent, request and pool counts.
    localparam int RUN_LIMIT    = 400000;  // far above the slowest correct run
    localparam int RESET_CYCLES = 12;
    localparam int HOLD_START   = 1000;    // receiver hold-off: the table backs up
    localparam int HOLD_LEN     = 250;
    localparam int FREE_START   = 2200;    // receiver always ready here
    localparam int FREE_LEN     = 600;
    localparam int IDLE_PCT     = 36;
    localparam int RANDOM_REQS  = 94;
    localparam int POOL_SIZE    = 24;
    localparam int DRAIN_CYCLES = 4 * NUM_TIMERS + 16;

    // One result as it travels on the m_ side.
    typedef struct packed {
        ptt_status_t          status;
        logic [HANDLER_W-1:0] handler;
        logic [CTX_W-1:0]     ctx;
        logic                 last;
    } timer_result_t;

    // One row of the directed table. Rows with typed set carry their single
    // result written out by hand; the others rely on the predictor.
    typedef struct packed {
        ptt_kind_t            kind;
        logic [HANDLER_W-1:0] handler;
        logic [CTX_W-1:0]     ctx;
        logic [PERIOD_W-1:0]  period;
        logic [TIME_W-1:0]    now;
        logic                 typed;
        ptt_status_t          exp_status;
        logic [HANDLER_W-1:0] exp_handler;
        logic [CTX_W-1:0]     exp_ctx;
    } directed_row_t;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;   // [7:0] handler_id, [23:8] context_id, [55:24] period,
                             // [103:56] now_time
    logic [1:0]   s_tuser;   // [1:0] kind
    logic         m_tvalid;
    logic         m_tready;
    logic [23:0]  m_tdata;   // [7:0] timer_handler, [23:8] timer_context
    logic [2:0]   m_tuser;   // [2:0] status
    logic         m_tlast;

    periodic_timer_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor copy of the timer table. Only entries below tbl_count are live.
    logic [HANDLER_W-1:0] tbl_handler  [NUM_TIMERS];
    logic [CTX_W-1:0]     tbl_context  [NUM_TIMERS];
    logic [PERIOD_W-1:0]  tbl_interval [NUM_TIMERS];
    logic [TIME_W-1:0]    tbl_due      [NUM_TIMERS];
    int                   tbl_count = 0;

    timer_result_t  fresh_results[$];    // results of the request just accepted
    timer_result_t  pending_results[$];  // results still owed by the block
    directed_row_t  directed_rows[$];

    logic [HANDLER_W-1:0] pool_handler [POOL_SIZE];
    logic [CTX_W-1:0]     pool_context [POOL_SIZE];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int sink_cycle     = 0;

    function automatic timer_result_t mk_result(input ptt_status_t st,
                                                input logic [HANDLER_W-1:0] h,
                                                input logic [CTX_W-1:0] c,
                                                input logic last);
        return {st, h, c, last};
    endfunction

    // Due times stick at the top of the 48-bit range instead of wrapping.
    function automatic logic [TIME_W-1:0] due_after(input logic [TIME_W-1:0] base,
                                                    input logic [PERIOD_W-1:0] step);
        logic [TIME_W:0] sum;
        sum = {1'b0, base} + {{(TIME_W + 1 - PERIOD_W){1'b0}}, step};
        return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

    // Applies one accepted request to the predictor table and leaves the
    // results it causes in fresh_results.
    function automatic void timer_table_step(input ptt_kind_t kind,
                                             input logic [HANDLER_W-1:0] h,
                                             input logic [CTX_W-1:0] c,
                                             input logic [PERIOD_W-1:0] per,
                                             input logic [TIME_W-1:0] now);
        int hit;
        hit = -1;
        fresh_results.delete();
        for (int i = 0; i < tbl_count; i++)
            if (hit < 0 && tbl_handler[i] == h && tbl_context[i] == c)
                hit = i;
        case (kind)
            KIND_SET: begin
                if (hit >= 0) begin
                    tbl_interval[hit] = per;
                    tbl_due[hit]      = due_after(now, per);
                    fresh_results = {fresh_results, mk_result(STAT_UPDATED, h, c, 1'b1)};
                end else if (tbl_count < NUM_TIMERS) begin
                    tbl_handler[tbl_count]  = h;
                    tbl_context[tbl_count]  = c;
                    tbl_interval[tbl_count] = per;
                    tbl_due[tbl_count]      = due_after(now, per);
                    tbl_count++;
                    fresh_results = {fresh_results, mk_result(STAT_ADDED, h, c, 1'b1)};
                end else begin
                    fresh_results = {fresh_results, mk_result(STAT_FULL, h, c, 1'b1)};
                end
            end
            KIND_REMOVE: begin
                if (hit < 0) begin
                    fresh_results = {fresh_results, mk_result(STAT_NOTFOUND, h, c, 1'b1)};
                end else begin
                    // close the gap, order of the rest kept
                    for (int i = hit; i < tbl_count - 1; i++) begin
                        tbl_handler[i]  = tbl_handler[i + 1];
                        tbl_context[i]  = tbl_context[i + 1];
                        tbl_interval[i] = tbl_interval[i + 1];
                        tbl_due[i]      = tbl_due[i + 1];
                    end
                    tbl_count--;
                    fresh_results = {fresh_results, mk_result(STAT_REMOVED, h, c, 1'b1)};
                end
            end
            KIND_TICK: begin
                for (int i = 0; i < tbl_count; i++) begin
                    if (now >= tbl_due[i]) begin
                        tbl_due[i] = due_after(tbl_due[i], tbl_interval[i]);
                        fresh_results = {fresh_results,
                                         mk_result(STAT_EXPIRED, tbl_handler[i],
                                                   tbl_context[i], 1'b0)};
                    end
                end
                if (fresh_results.size() == 0)
                    fresh_results = {fresh_results, mk_result(STAT_IDLE, '0, '0, 1'b1)};
                else
                    fresh_results[fresh_results.size() - 1].last = 1'b1;
            end
            default: ;  // unused kind: taken and dropped
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("%0t ns: mismatch on %s, got 'h%0h, expected 'h%0h", $realtime, what,
                 got, want);
        mismatch_count++;
    endtask

    task automatic check_result();
        timer_result_t want;
        if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending",
                            48'({m_tuser, m_tdata, m_tlast}), 48'd0);
        end else begin
            want = pending_results.pop_front();
            if (m_tuser !== want.status)
                report_mismatch("status", 48'(m_tuser), 48'(want.status));
            if (m_tdata[7:0] !== want.handler)
                report_mismatch("timer_handler", 48'(m_tdata[7:0]), 48'(want.handler));
            if (m_tdata[23:8] !== want.ctx)
                report_mismatch("timer_context", 48'(m_tdata[23:8]), 48'(want.ctx));
            if (m_tlast !== want.last)
                report_mismatch("final_result", 48'(m_tlast), 48'(want.last));
        end
    endtask

    // Results are sampled at the rising edge, before the block's own updates land.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_result();
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off that backs the table up into
    // s_tready, and one stretch with m_tready held high.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            sink_cycle++;
            if (sink_cycle >= HOLD_START && sink_cycle < HOLD_START + HOLD_LEN)
                m_tready <= 1'b0;
            else if (sink_cycle >= FREE_START && sink_cycle < FREE_START + FREE_LEN)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic add_row(input ptt_kind_t kind, input logic [HANDLER_W-1:0] h,
                           input logic [CTX_W-1:0] c, input logic [PERIOD_W-1:0] per,
                           input logic [TIME_W-1:0] now, input logic typed,
                           input ptt_status_t st, input logic [HANDLER_W-1:0] eh,
                           input logic [CTX_W-1:0] ec);
        directed_row_t new_row;
        new_row = {kind, h, c, per, now, typed, st, eh, ec};
        directed_rows = {directed_rows, new_row};
    endtask

    // Offers one request; entered and left at a falling edge. Random gaps go in
    // front unless steady is set. The predictor runs at the accepting edge; a
    // typed expectation replaces its result.
    task automatic send_request(input ptt_kind_t kind, input logic [HANDLER_W-1:0] h,
                                input logic [CTX_W-1:0] c, input logic [PERIOD_W-1:0] per,
                                input logic [TIME_W-1:0] now, input logic steady,
                                input logic typed, input timer_result_t typed_result);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {now, per, c, h};
        do @(posedge aclk); while (!s_tready);
        timer_table_step(kind, h, c, per, now);
        if (typed)
            pending_results = {pending_results, typed_result};
        else
            pending_results = {pending_results, fresh_results};
        @(negedge aclk);
    endtask

    initial begin
        directed_row_t row;
        ptt_kind_t            kind;
        logic [HANDLER_W-1:0] h;
        logic [CTX_W-1:0]     c;
        logic [PERIOD_W-1:0]  per;
        logic [TIME_W-1:0]    now;
        logic [TIME_W-1:0]    clock_ms;
        int                   pick;
        int                   sent;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_SET;

        // Directed table. Empty table first, then zero period and saturation,
        // then fill to the brim, overflow, a remove from the middle, a wide tick.
        add_row(KIND_TICK,   8'h00, 16'h0000, 32'h0, 48'h0, 1'b1, STAT_IDLE, 8'h00, 16'h0000);
        add_row(KIND_REMOVE, 8'hFF, 16'hFFFF, 32'h0, 48'h0, 1'b1, STAT_NOTFOUND,
                8'hFF, 16'hFFFF);
        // unused kind: no result, no change
        add_row(KIND_NONE, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0,
                STAT_ADDED, 8'h00, 16'h0000);
        // zero period: due again on every tick from now on
        add_row(KIND_SET, 8'h00, 16'h0000, 32'h0, 48'h0, 1'b1, STAT_ADDED, 8'h00, 16'h0000);
        // due time saturates at the top of the range
        add_row(KIND_SET, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFF0, 1'b1,
                STAT_ADDED, 8'hFF, 16'hFFFF);
        add_row(KIND_SET, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 48'hFFFF_0000_0000, 1'b1,
                STAT_UPDATED, 8'hFF, 16'hFFFF);
        add_row(KIND_TICK, 8'h00, 16'h0000, 32'h0, 48'h0, 1'b0, STAT_ADDED, 8'h00, 16'h0000);
        add_row(KIND_TICK, 8'h00, 16'h0000, 32'h0, 48'hFFFF_FFFF_FFFF, 1'b0,
                STAT_ADDED, 8'h00, 16'h0000);
        add_row(KIND_TICK, 8'h5A, 16'hA5A5, 32'h1234_5678, 48'hFFFF_FFFF_FFFF, 1'b0,
                STAT_ADDED, 8'h00, 16'h0000);
        for (int i = 0; i < NUM_TIMERS - 2; i++)
            add_row(KIND_SET, 8'(i + 1), 16'(16'h1111 * (i + 1)), 32'd1 << (2 * i),
                    48'd1000, 1'b1, STAT_ADDED, 8'(i + 1), 16'(16'h1111 * (i + 1)));
        // table full: dropped, own key reported
        add_row(KIND_SET, 8'h80, 16'h8000, 32'd50, 48'd1000, 1'b1, STAT_FULL, 8'h80, 16'h8000);
        add_row(KIND_REMOVE, 8'h05, 16'h5555, 32'h0, 48'h0, 1'b1, STAT_REMOVED,
                8'h05, 16'h5555);
        add_row(KIND_TICK, 8'h00, 16'h0000, 32'h0, 48'h0000_1000_0000, 1'b0,
                STAT_ADDED, 8'h00, 16'h0000);

        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_handler[i] = 8'($urandom);
            pool_context[i] = 16'($urandom);
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_request(row.kind, row.handler, row.ctx, row.period, row.now, 1'b0,
                         row.typed, mk_result(row.exp_status, row.exp_handler,
                                              row.exp_ctx, 1'b1));
        end

        // Random part: keys mostly from a small pool so that updates, removes
        // and a full table keep turning up; time mostly runs forward in small
        // steps so ticks catch timers in varying numbers.
        clock_ms = 48'h0000_2000_0000;
        sent = 0;
        while (sent < RANDOM_REQS) begin
            pick = $urandom_range(99);
            if (pick < 5)
                kind = KIND_NONE;
            else if (pick < 45)
                kind = KIND_SET;
            else if (pick < 65)
                kind = KIND_REMOVE;
            else
                kind = KIND_TICK;

            pick = $urandom_range(POOL_SIZE - 1);
            if ($urandom_range(99) < 85) begin
                h = pool_handler[pick];
                c = pool_context[pick];
            end else begin
                h = 8'($urandom);
                c = 16'($urandom);
            end

            pick = $urandom_range(99);
            if (pick < 10)
                per = '0;
            else if (pick < 80)
                per = $urandom_range(300, 1);
            else if (pick < 90)
                per = $urandom_range(100000, 300);
            else
                per = $urandom;

            clock_ms = clock_ms + $urandom_range(120);
            if ($urandom_range(99) < 8)
                now = {16'($urandom), 32'($urandom)};
            else
                now = clock_ms;

            send_request(kind, h, c, per, now, (sent >= 40 && sent < 70), 1'b0,
                         mk_result(STAT_ADDED, '0, '0, 1'b0));
            sent++;
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        // any stray result after the last expected one still gets caught
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
